[rtl/k_way_sorted_merge_top_defines.svh]
// Assertion macros used by the checker file of the merge block.
`ifndef K_WAY_SORTED_MERGE_TOP_DEFINES_SVH
`define K_WAY_SORTED_MERGE_TOP_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define KWM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define KWM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/kwm_pkg.sv]
// Package with the constants, command types and the minimum helper of the merge block.
package kwm_pkg;

    localparam int MAX_LISTS   = 16;
    localparam int VALUE_WIDTH = 32;
    localparam int LIST_W      = 4;
    localparam int SLOT_W      = $clog2(MAX_LISTS);
    localparam int GROUPS      = 4;
    localparam int GROUP_SIZE  = MAX_LISTS / GROUPS;
    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = PTR_W + 1;

    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_REFILL = 1'b1;

    typedef enum logic [2:0] {
        CMD_LOAD      = 3'b001,
        CMD_LOAD_LAST = 3'b010,
        CMD_REFILL    = 3'b100
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t                kind;
        logic [LIST_W-1:0]        list_index;
        logic [VALUE_WIDTH-1:0]   value;
        logic                     present;
    } cmd_t;

    typedef struct packed {
        logic                     valid;
        logic [SLOT_W-1:0]        slot;
        logic [VALUE_WIDTH-1:0]   value;
    } cand_t;

    // The lower slot wins a tie, so the second candidate must be strictly smaller.
    function automatic cand_t pick_min(cand_t a, cand_t b);
        cand_t res;
        if (b.valid && (!a.valid || ($signed(b.value) < $signed(a.value))))
        begin
            res = b;
        end
        else
        begin
            res = a;
        end
        return res;
    endfunction

endpackage

[rtl/kwm_front.sv]
// Front end: accepts items, classifies them into commands and queues them.
module kwm_front
    import kwm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_stall,
    input  logic                   func,
    input  logic [LIST_W-1:0]      list_index,
    input  logic [VALUE_WIDTH-1:0] value,
    input  logic                   present,
    input  logic                   last_list,
    output cmd_t                   cmd,
    output logic                   cmd_valid,
    input  logic                   cmd_take
);

    cmd_t             queue_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    cmd_t             new_cmd;
    logic             push;
    logic             pop;

    assign item_stall = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign cmd_valid  = (count_reg != '0);
    assign cmd        = queue_reg[rd_ptr_reg];
    assign push       = item_valid && !item_stall;
    assign pop        = cmd_take && cmd_valid;

    always_comb
    begin
        new_cmd.list_index = list_index;
        new_cmd.value      = value;
        new_cmd.present    = present;
        if (func == FUNC_REFILL)
        begin
            new_cmd.kind = CMD_REFILL;
        end
        else if (last_list)
        begin
            new_cmd.kind = CMD_LOAD_LAST;
        end
        else
        begin
            new_cmd.kind = CMD_LOAD;
        end
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= new_cmd;
        end
    end

endmodule

[rtl/kwm_back.sv]
// Back end: holds the list heads, finds the smallest one in two tree stages and emits it.
module kwm_back
    import kwm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  cmd_t                   cmd,
    input  logic                   cmd_valid,
    output logic                   cmd_take,
    output logic                   result_valid,
    input  logic                   result_stall,
    output logic [VALUE_WIDTH-1:0] merged_value,
    output logic [LIST_W-1:0]      source_list,
    output logic                   element_valid,
    output logic                   done_res
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_REDUCE = 3'b010,
        ST_SELECT = 3'b100
    } state_t;

    state_t                 state_reg;
    state_t                 state_next;
    logic [VALUE_WIDTH-1:0] head_value_reg [MAX_LISTS];
    logic                   head_valid_reg [MAX_LISTS];
    logic [SLOT_W-1:0]      pending_reg;
    logic [SLOT_W-1:0]      pending_next;
    logic                   merging_reg;
    logic                   merging_next;
    cand_t                  group_reg [GROUPS];
    cand_t                  group_next [GROUPS];
    cand_t                  best;
    logic                   result_valid_reg;
    logic                   result_valid_next;
    logic [VALUE_WIDTH-1:0] merged_value_reg;
    logic [LIST_W-1:0]      source_list_reg;
    logic                   element_valid_reg;
    logic                   done_res_reg;
    logic                   load_out;
    logic                   out_free;
    logic                   wr_en;
    logic [SLOT_W-1:0]      wr_slot;
    logic                   clr_en;

    assign result_valid  = result_valid_reg;
    assign merged_value  = merged_value_reg;
    assign source_list   = source_list_reg;
    assign element_valid = element_valid_reg;
    assign done_res      = done_res_reg;
    assign cmd_take      = (state_reg == ST_IDLE) && cmd_valid;
    assign out_free      = !result_valid_reg || !result_stall;

    always_comb
    begin
        cand_t cur;
        cand_t leaf;
        for (int g = 0; g < GROUPS; g++)
        begin
            cur = '0;
            for (int i = 0; i < GROUP_SIZE; i++)
            begin
                leaf.valid = head_valid_reg[g * GROUP_SIZE + i];
                leaf.slot  = SLOT_W'(g * GROUP_SIZE + i);
                leaf.value = head_value_reg[g * GROUP_SIZE + i];
                cur        = pick_min(cur, leaf);
            end
            group_next[g] = cur;
        end
    end

    always_comb
    begin
        best = '0;
        for (int g = 0; g < GROUPS; g++)
        begin
            best = pick_min(best, group_reg[g]);
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        pending_next      = pending_reg;
        merging_next      = merging_reg;
        wr_en             = 1'b0;
        wr_slot           = cmd.list_index[SLOT_W-1:0];
        clr_en            = 1'b0;
        load_out          = 1'b0;
        result_valid_next = result_valid_reg && result_stall;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    unique case (cmd.kind)
                        CMD_LOAD, CMD_LOAD_LAST:
                        begin
                            if (!merging_reg)
                            begin
                                wr_en = ({1'b0, cmd.list_index} < (LIST_W + 1)'(MAX_LISTS));
                                if (cmd.kind == CMD_LOAD_LAST)
                                begin
                                    state_next = ST_REDUCE;
                                end
                            end
                        end
                        CMD_REFILL:
                        begin
                            if (merging_reg)
                            begin
                                wr_en      = cmd.present;
                                wr_slot    = pending_reg;
                                state_next = ST_REDUCE;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_REDUCE:
            begin
                state_next = ST_SELECT;
            end
            ST_SELECT:
            begin
                if (out_free)
                begin
                    load_out          = 1'b1;
                    result_valid_next = 1'b1;
                    clr_en            = best.valid;
                    merging_next      = best.valid;
                    if (best.valid)
                    begin
                        pending_next = best.slot;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            pending_reg      <= '0;
            merging_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_LISTS; i++)
            begin
                head_valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            state_reg        <= state_next;
            pending_reg      <= pending_next;
            merging_reg      <= merging_next;
            result_valid_reg <= result_valid_next;
            if (wr_en)
            begin
                head_valid_reg[wr_slot] <= cmd.present;
            end
            if (clr_en)
            begin
                head_valid_reg[best.slot] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && cmd.present)
        begin
            head_value_reg[wr_slot] <= cmd.value;
        end
        if (state_reg == ST_REDUCE)
        begin
            for (int g = 0; g < GROUPS; g++)
            begin
                group_reg[g] <= group_next[g];
            end
        end
        if (load_out)
        begin
            element_valid_reg <= best.valid;
            done_res_reg      <= !best.valid;
            merged_value_reg  <= best.valid ? best.value : '0;
            source_list_reg   <= best.valid ? LIST_W'(best.slot) : '0;
        end
    end

endmodule

[rtl/k_way_sorted_merge_top.sv]
// Top level of the k-way sorted merge block: front end, command queue and back end.
//
//   Channel   Direction   Handshake                    Fields
//   item      in          item_valid / item_stall      func list_index value present last_list
//   result    out         result_valid / result_stall  merged_value source_list element_valid
//                                                       done_res
//
// A load without the last-list flag only updates a head in the back end; an item that pops goes
// through head update, first tree stage over four groups of four heads, then final selection.
// The two-entry queue lets the front take items while the back end is busy.
// Reset clears all head valid bits, the merge state, the queue pointers and count, and the result valid flag.
// A stalled result holds the back end in selection until the transfer can complete.
module k_way_sorted_merge_top
    import kwm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_stall,
    input  logic                   func,
    input  logic [LIST_W-1:0]      list_index,
    input  logic [VALUE_WIDTH-1:0] value,
    input  logic                   present,
    input  logic                   last_list,
    output logic                   result_valid,
    input  logic                   result_stall,
    output logic [VALUE_WIDTH-1:0] merged_value,
    output logic [LIST_W-1:0]      source_list,
    output logic                   element_valid,
    output logic                   done_res
);

    cmd_t cmd;
    logic cmd_valid;
    logic cmd_take;

    kwm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .func       (func),
        .list_index (list_index),
        .value      (value),
        .present    (present),
        .last_list  (last_list),
        .cmd        (cmd),
        .cmd_valid  (cmd_valid),
        .cmd_take   (cmd_take)
    );

    kwm_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .cmd_valid     (cmd_valid),
        .cmd_take      (cmd_take),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .merged_value  (merged_value),
        .source_list   (source_list),
        .element_valid (element_valid),
        .done_res      (done_res)
    );

endmodule

[rtl/kwm_checker.sv]
// Port-level checker for the merge block and its bind to the top level.
`include "k_way_sorted_merge_top_defines.svh"

module kwm_checker
    import kwm_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   item_valid,
    input logic                   item_stall,
    input logic                   result_valid,
    input logic                   result_stall,
    input logic [VALUE_WIDTH-1:0] merged_value,
    input logic [LIST_W-1:0]      source_list,
    input logic                   element_valid,
    input logic                   done_res
);

    `KWM_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(merged_value) && $stable(source_list) && $stable(done_res), "stalled result changed")
    `KWM_ASSERT_NOW(a_kind_excl, result_valid, element_valid != done_res, "result must be either an element or done")
    `KWM_ASSERT_NOW(a_done_zero, result_valid && done_res, (merged_value == '0) && (source_list == '0), "done result carries nonzero fields")
    `KWM_ASSERT_NEXT(a_stall_needs_transfer, !item_valid && !item_stall, !item_stall, "item stall rose without a transfer")

endmodule

bind k_way_sorted_merge_top kwm_checker u_kwm_checker (.*);
